@@ rtl/core/tdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared types, constants and the arctangent table of the tilt detector.
// ----------------------------------------------------------------------------
package tdd_pkg;

   localparam int ConfirmCountDef = 3;
   localparam int CordicSteps     = 16;
   localparam int SquareSteps     = 17;
   localparam int RootSteps       = 30;

   localparam logic [8:0]  AlphaReset  = 9'd64;
   localparam logic [8:0]  AlphaMax    = 9'd256;
   localparam logic [14:0] ThreshReset = 15'd1920;

   // +180 degrees in 1/32768 degree units
   localparam logic signed [25:0] HalfTurn = 26'sd5898240;

   typedef enum logic [1:0] {
      GO_RIGHT = 2'd0,
      GO_UP    = 2'd1,
      GO_DOWN  = 2'd2,
      GO_LEFT  = 2'd3
   } dir_type;

   typedef enum logic {
      CSR_ALPHA  = 1'b0,
      CSR_THRESH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_ROOT,
      ST_PITCH,
      ST_FILT
   } state_type;

   function automatic logic [20:0] atan_lut(input logic [3:0] idx);
      logic [20:0] v;
      case (idx)
         4'd0:    v = 21'd1474560;
         4'd1:    v = 21'd870484;
         4'd2:    v = 21'd459940;
         4'd3:    v = 21'd233473;
         4'd4:    v = 21'd117189;
         4'd5:    v = 21'd58652;
         4'd6:    v = 21'd29333;
         4'd7:    v = 21'd14667;
         4'd8:    v = 21'd7334;
         4'd9:    v = 21'd3667;
         4'd10:   v = 21'd1833;
         4'd11:   v = 21'd917;
         4'd12:   v = 21'd458;
         4'd13:   v = 21'd229;
         4'd14:   v = 21'd115;
         4'd15:   v = 21'd57;
         default: v = 21'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/core/tilt_direction_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_direction_detector
// Roll/pitch from a 3-axis sample, calibration, low-pass and direction vote.
// ----------------------------------------------------------------------------
// sequence: after a word is accepted, square/roll cordic, root digits and pitch
//    cordic steps run in turn, then the filter step writes the output register
// throughput: one word at a time, no new word until its result is committed,
//    set by the single shared cordic stage and the one-digit-per-cycle square root
// reset: synchronous, clears state to uncalibrated, alpha 64, threshold 1920
module tilt_direction_detector
   import tdd_pkg::*;
#(
   parameter int CONFIRM_COUNT = ConfirmCountDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // direction, smoothed_roll, smoothed_pitch, pad
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int RepW = $clog2(CONFIRM_COUNT + 1);

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [8:0]  alpha_ff;
   logic [14:0] thresh_ff;

   logic               calib_ff, action_ff, zvec_ff;
   logic signed [15:0] ax_ff;
   logic signed [15:0] rz_ff, pz_ff;
   logic signed [16:0] rs_ff, ps_ff, roll_ff;
   logic [1:0]         held_ff, pend_ff;
   logic [RepW-1:0]    rep_ff;

   logic signed [35:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [25:0] cz_ff, cz_in;

   logic [31:0] mca_ff, mcb_ff, acc_ff;
   logic [16:0] mpa_ff, mpb_ff;

   logic [59:0] n_ff;
   logic [33:0] rem_ff, rem_in;
   logic [29:0] root_ff, root_in;

   logic        rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;

   logic accept, last_step, commit;

   assign accept = req_tvalid && req_tready;
   assign commit = (state_ff == ST_FILT) && (!rsp_tvalid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ANGLE;
         ST_ANGLE: if (cnt_ff == 5'(SquareSteps - 1)) state_in = ST_ROOT;
         ST_ROOT:  if (cnt_ff == 5'(RootSteps - 1)) state_in = ST_PITCH;
         ST_PITCH: if (cnt_ff == 5'(CordicSteps - 1)) state_in = ST_FILT;
         ST_FILT:  if (commit) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      last_step  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ANGLE: last_step = (cnt_ff == 5'(SquareSteps - 1));
         ST_ROOT:  last_step = (cnt_ff == 5'(RootSteps - 1));
         ST_PITCH: last_step = (cnt_ff == 5'(CordicSteps - 1));
         default:  last_step = 1'b0;
      endcase
   end

   always_comb begin
      cnt_in = (last_step || state_ff == ST_IDLE) ? 5'd0 : cnt_ff + 5'd1;
   end

   // input unpacking and roll setup
   logic signed [15:0] ix, iy, iz;
   logic [16:0]        aby, abz;
   logic signed [35:0] ysc, zsc, xsc;

   always_comb begin
      ix  = req_tdata[15:0];
      iy  = req_tdata[31:16];
      iz  = req_tdata[47:32];
      aby = iy[15] ? 17'(-{iy[15], iy}) : {iy[15], iy};
      abz = iz[15] ? 17'(-{iz[15], iz}) : {iz[15], iz};
      ysc = {{6{iy[15]}}, iy, 14'd0};
      zsc = {{6{iz[15]}}, iz, 14'd0};
      xsc = {{6{ax_ff[15]}}, ax_ff, 14'd0};
   end

   // one cordic vectoring step, floor shifts
   logic [3:0]         sh;
   logic signed [35:0] dx, dy;
   logic signed [25:0] at;

   always_comb begin
      sh = cnt_ff[3:0];
      dx = cy_ff >>> sh;
      dy = cx_ff >>> sh;
      at = $signed({5'd0, atan_lut(sh)});
      if (!cy_ff[35]) begin
         cx_in = cx_ff + dx;
         cy_in = cy_ff - dy;
         cz_in = cz_ff + at;
      end else begin
         cx_in = cx_ff - dx;
         cy_in = cy_ff + dy;
         cz_in = cz_ff - at;
      end
   end

   // one root digit per cycle
   logic [33:0] r2, trial;
   logic        ge;

   always_comb begin
      r2      = {rem_ff[31:0], n_ff[59:58]};
      trial   = {2'd0, root_ff, 2'b01};
      ge      = (r2 >= trial);
      rem_in  = ge ? r2 - trial : r2;
      root_in = {root_ff[28:0], ge};
   end

   // round cordic angle to 1/128 degree
   logic signed [25:0] zr;
   logic signed [16:0] angle_q;

   always_comb begin
      zr      = cz_ff + 26'sd128;
      angle_q = zvec_ff ? 17'sd0 : zr[24:8];
   end

   // filter and direction vote
   logic signed [17:0] cal_r, cal_p;
   logic signed [18:0] dif_r, dif_p;
   logic signed [28:0] prd_r, prd_p, sum_r, sum_p;
   logic signed [16:0] rs_new, ps_new;
   logic [16:0]        mag_r, mag_p;
   logic [1:0]         dir;
   logic [RepW:0]      rep_inc;
   logic               dead;

   always_comb begin
      cal_r   = {roll_ff[16], roll_ff} - {{2{rz_ff[15]}}, rz_ff};
      cal_p   = {angle_q[16], angle_q} - {{2{pz_ff[15]}}, pz_ff};
      dif_r   = {cal_r[17], cal_r} - {{2{rs_ff[16]}}, rs_ff};
      dif_p   = {cal_p[17], cal_p} - {{2{ps_ff[16]}}, ps_ff};
      prd_r   = $signed({1'b0, alpha_ff}) * dif_r;
      prd_p   = $signed({1'b0, alpha_ff}) * dif_p;
      sum_r   = {{4{rs_ff[16]}}, rs_ff, 8'd0} + prd_r + 29'sd128;
      sum_p   = {{4{ps_ff[16]}}, ps_ff, 8'd0} + prd_p + 29'sd128;
      rs_new  = sum_r[24:8];
      ps_new  = sum_p[24:8];
      mag_r   = rs_new[16] ? 17'(-rs_new) : rs_new;
      mag_p   = ps_new[16] ? 17'(-ps_new) : ps_new;
      dead    = (mag_r < {2'd0, thresh_ff}) && (mag_p < {2'd0, thresh_ff});
      if (mag_p > mag_r) dir = (!ps_new[16] && ps_new != 17'sd0) ? GO_UP : GO_DOWN;
      else dir = rs_new[16] ? GO_LEFT : GO_RIGHT;
      rep_inc = {1'b0, rep_ff} + (RepW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= 5'd0;
         alpha_ff      <= AlphaReset;
         thresh_ff     <= ThreshReset;
         calib_ff      <= 1'b0;
         rz_ff         <= '0;
         pz_ff         <= '0;
         rs_ff         <= '0;
         ps_ff         <= '0;
         held_ff       <= GO_RIGHT;
         pend_ff       <= GO_RIGHT;
         rep_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_ALPHA:
                  alpha_ff <= (csr_wdata[8:0] > AlphaMax) ? AlphaMax : csr_wdata[8:0];
               CSR_THRESH: thresh_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (commit) begin
            rsp_tvalid_ff <= 1'b1;
            if (action_ff) begin
               rz_ff    <= roll_ff[15:0];
               pz_ff    <= angle_q[15:0];
               rs_ff    <= '0;
               ps_ff    <= '0;
               held_ff  <= GO_RIGHT;
               pend_ff  <= GO_RIGHT;
               rep_ff   <= '0;
               calib_ff <= 1'b1;
            end else if (calib_ff) begin
               rs_ff <= rs_new;
               ps_ff <= ps_new;
               if (dead) begin
                  rep_ff  <= '0;
                  pend_ff <= held_ff;
               end else if (dir == pend_ff) begin
                  if (rep_inc >= (RepW + 1)'(CONFIRM_COUNT)) begin
                     held_ff <= dir;
                     rep_ff  <= RepW'(CONFIRM_COUNT);
                  end else begin
                     rep_ff <= rep_inc[RepW-1:0];
                  end
               end else begin
                  pend_ff <= dir;
                  rep_ff  <= RepW'(1);
               end
            end
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_tuser;
         ax_ff     <= ix;
         zvec_ff   <= (iy == 16'sd0) && (iz == 16'sd0);
         mca_ff    <= {15'd0, aby};
         mcb_ff    <= {15'd0, abz};
         mpa_ff    <= aby;
         mpb_ff    <= abz;
         acc_ff    <= '0;
         if (!iz[15]) begin
            cx_ff <= zsc;
            cy_ff <= ysc;
            cz_ff <= '0;
         end else begin
            cx_ff <= -zsc;
            cy_ff <= -ysc;
            cz_ff <= iy[15] ? -HalfTurn : HalfTurn;
         end
      end
      case (state_ff)
         ST_ANGLE: begin
            acc_ff <= acc_ff + (mpa_ff[0] ? mca_ff : 32'd0) + (mpb_ff[0] ? mcb_ff : 32'd0);
            mca_ff <= mca_ff << 1;
            mcb_ff <= mcb_ff << 1;
            mpa_ff <= mpa_ff >> 1;
            mpb_ff <= mpb_ff >> 1;
            if (cnt_ff < 5'(CordicSteps)) begin
               cx_ff <= cx_in;
               cy_ff <= cy_in;
               cz_ff <= cz_in;
            end
            if (last_step) begin
               roll_ff <= angle_q;
               n_ff    <= {acc_ff + (mpa_ff[0] ? mca_ff : 32'd0)
                           + (mpb_ff[0] ? mcb_ff : 32'd0), 28'd0};
               rem_ff  <= '0;
               root_ff <= '0;
            end
         end
         ST_ROOT: begin
            n_ff    <= n_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            if (last_step) begin
               cx_ff <= {6'd0, root_in};
               cy_ff <= -xsc;
               cz_ff <= '0;
            end
         end
         ST_PITCH: begin
            cx_ff <= cx_in;
            cy_ff <= cy_in;
            cz_ff <= cz_in;
         end
         default: ;
      endcase
      if (commit) begin
         if (action_ff)
            rsp_tdata_ff <= {4'd0, 17'd0, 17'd0, GO_RIGHT};
         else if (calib_ff)
            rsp_tdata_ff <= {4'd0, ps_new, rs_new,
                             (!dead && dir == pend_ff
                              && rep_inc >= (RepW + 1)'(CONFIRM_COUNT)) ? dir : held_ff};
         else
            rsp_tdata_ff <= {4'd0, ps_ff, rs_ff, held_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ANGLE) else $error("sequencer did not start");
   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_ff <= RepW'(CONFIRM_COUNT)) else $error("repeat count beyond limit");
   a_uncal_zero: assert property (@(posedge clock) disable iff (reset)
      !calib_ff |-> (rs_ff == 17'sd0 && ps_ff == 17'sd0)) else $error("filter moved uncalibrated");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !commit) else $error("result overwritten");
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> cnt_ff < 5'(RootSteps)) else $error("root step count");

endmodule

@@ tb/tilt_direction_detector_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_direction_detector_check
// Watches the sample, result and register ports of the tilt detector, works
// out the expected direction and filtered angles for every accepted sample
// and compares them in order with the results that leave the block.
// ----------------------------------------------------------------------------
module tilt_direction_detector_check
   import tdd_pkg::*;
#(
   parameter int CONFIRM_COUNT = ConfirmCountDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   input  logic        req_tuser,   // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // direction, smoothed_roll, smoothed_pitch, pad
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      dir_type            dir;
      logic signed [16:0] roll;
      logic signed [16:0] pitch;
   } tilt_result_type;

   tilt_result_type tilt_expected_q[$];

   longint  alpha, thresh;
   longint  roll_ofs, pitch_ofs, roll_filt, pitch_filt;
   bit      calibrated;
   dir_type held_dir, pend_dir;
   int      run_len;

   assign pending = tilt_expected_q.size();

   function automatic longint round_q8(longint v);
      return (v + 128) >>> 8;
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   // vectoring rotation, x >= 0, angle in 1/32768 degree
   function automatic longint vector_deg(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + longint'(atan_lut(i[3:0]));
         end else begin
            x = x - dx; y = y + dy; z = z - longint'(atan_lut(i[3:0]));
         end
      end
      return z;
   endfunction

   function automatic longint roll_angle(longint ay, longint az);
      if (ay == 0 && az == 0) return 0;
      if (az >= 0) return round_q8(vector_deg(az * 16384, ay * 16384));
      return round_q8((ay >= 0 ? longint'(HalfTurn) : -longint'(HalfTurn))
                      + vector_deg(-az * 16384, -ay * 16384));
   endfunction

   function automatic longint pitch_angle(longint ax, longint ay, longint az);
      longint unsigned s;
      s = longint'(ay * ay + az * az);
      if (s == 0) return 0;
      return round_q8(vector_deg(root_floor(s << 28), -ax * 16384));
   endfunction

   task automatic predict_tilt(input bit cal, input longint ax, input longint ay,
                               input longint az);
      tilt_result_type r;
      longint mr, mp;
      dir_type d;
      if (cal) begin
         roll_ofs   = roll_angle(ay, az);
         pitch_ofs  = pitch_angle(ax, ay, az);
         roll_filt  = 0;
         pitch_filt = 0;
         held_dir   = GO_RIGHT;
         pend_dir   = GO_RIGHT;
         run_len    = 0;
         calibrated = 1;
      end else if (calibrated) begin
         roll_filt  = round_q8(alpha * (roll_angle(ay, az) - roll_ofs)
                               + (256 - alpha) * roll_filt);
         pitch_filt = round_q8(alpha * (pitch_angle(ax, ay, az) - pitch_ofs)
                               + (256 - alpha) * pitch_filt);
         mr = roll_filt < 0 ? -roll_filt : roll_filt;
         mp = pitch_filt < 0 ? -pitch_filt : pitch_filt;
         if (mr < thresh && mp < thresh) begin
            run_len  = 0;
            pend_dir = held_dir;
         end else begin
            if (mp > mr) d = pitch_filt > 0 ? GO_UP : GO_DOWN;
            else         d = roll_filt >= 0 ? GO_RIGHT : GO_LEFT;
            if (d == pend_dir) begin
               run_len++;
               if (run_len >= CONFIRM_COUNT) begin
                  held_dir = d;
                  run_len  = CONFIRM_COUNT;
               end
            end else begin
               pend_dir = d;
               run_len  = 1;
            end
         end
      end
      r.dir   = held_dir;
      r.roll  = roll_filt[16:0];
      r.pitch = pitch_filt[16:0];
      tilt_expected_q.push_back(r);
   endtask

   always @(posedge clock) begin
      tilt_result_type e, a;
      if (reset) begin
         alpha      = longint'(AlphaReset);
         thresh     = longint'(ThreshReset);
         roll_ofs   = 0;
         pitch_ofs  = 0;
         roll_filt  = 0;
         pitch_filt = 0;
         calibrated = 0;
         held_dir   = GO_RIGHT;
         pend_dir   = GO_RIGHT;
         run_len    = 0;
         fail_count = 0;
         tilt_expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            a.dir   = dir_type'(rsp_tdata[1:0]);
            a.roll  = rsp_tdata[18:2];
            a.pitch = rsp_tdata[35:19];
            if (tilt_expected_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $realtime, rsp_tdata);
               fail_count++;
            end else begin
               e = tilt_expected_q.pop_front();
               if (a.dir !== e.dir) begin
                  $display("%0t: direction expected %0d actual %0d", $realtime,
                           e.dir, a.dir);
                  fail_count++;
               end
               if (a.roll !== e.roll) begin
                  $display("%0t: smoothed_roll expected %0d actual %0d", $realtime,
                           e.roll, a.roll);
                  fail_count++;
               end
               if (a.pitch !== e.pitch) begin
                  $display("%0t: smoothed_pitch expected %0d actual %0d", $realtime,
                           e.pitch, a.pitch);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_tilt(req_tuser, longint'($signed(req_tdata[15:0])),
                         longint'($signed(req_tdata[31:16])),
                         longint'($signed(req_tdata[47:32])));
         if (csr_wen) begin
            if (csr_index == CSR_ALPHA)
               alpha = longint'(csr_wdata[8:0] > AlphaMax ? AlphaMax : csr_wdata[8:0]);
            else
               thresh = longint'(csr_wdata);
         end
      end
   end

endmodule

@@ tb/tilt_direction_detector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_direction_detector_test
// Drives accelerometer samples and register writes into the tilt detector:
// directed corner samples, then calibrate-and-hold tilt sequences mixed with
// noise under several filter and dead-zone settings, with random gaps on
// both ports. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tilt_direction_detector_test;
   import tdd_pkg::*;

   localparam int WatchLimit = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_wen = 0;
   logic        csr_index = CSR_ALPHA;
   logic [14:0] csr_wdata = '0;
   int          fail_count, pending;
   int          sent = 0;
   int          idle_cnt = 0;
   bit          quiet = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   tilt_direction_detector u_top (.*);

   tilt_direction_detector_check u_check (.*);

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= quiet || ($urandom_range(99) >= 13);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= WatchLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   task automatic send_sample(input bit cal, input logic [15:0] ax,
                              input logic [15:0] ay, input logic [15:0] az);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 13) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cal;
      req_tdata  <= {az, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // drain, then let the block finish before touching registers
   task automatic drain_and_write(input csr_index_type idx, input logic [14:0] val);
      @(negedge clock);
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wen   <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 0;
   endtask

   function automatic logic [15:0] sat16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic tilt_run(input int n);
      int bx, by, bz, sh;
      sh = $urandom_range(0, 3);
      bx = int'($signed(16'($urandom()))) >>> sh;
      by = int'($signed(16'($urandom()))) >>> sh;
      bz = int'($signed(16'($urandom()))) >>> sh;
      for (int i = 0; i < n; i++)
         send_sample(1'b0, sat16(bx + $urandom_range(0, 600) - 300),
                     sat16(by + $urandom_range(0, 600) - 300),
                     sat16(bz + $urandom_range(0, 600) - 300));
   endtask

   task automatic random_phase(input int n_items);
      int target;
      target = sent + n_items;
      while (sent < target) begin
         if ($urandom_range(99) < 12) begin
            send_sample(1'($urandom_range(1)), 16'($urandom()), 16'($urandom()),
                        16'($urandom()));
         end else begin
            if ($urandom_range(99) < 40)
               send_sample(1'b1, sat16(int'($signed(16'($urandom()))) >>> 4),
                           sat16(int'($signed(16'($urandom()))) >>> 4),
                           sat16(int'($signed(16'($urandom()))) >>> 1));
            tilt_run($urandom_range(3, 12));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // update before calibration, then zero-vector calibration
      send_sample(1'b0, 16'd100, 16'd200, 16'd300);
      send_sample(1'b1, 16'h7fff, 16'd0, 16'd0);
      send_sample(1'b0, 16'd0, 16'd0, 16'd0);
      send_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
      send_sample(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(1'b0, 16'h8000, 16'h7fff, 16'h8000);
      send_sample(1'b0, 16'd0, 16'hffff, 16'h8000);
      send_sample(1'b0, 16'd0, 16'd0, 16'h8000);
      send_sample(1'b0, 16'd0, 16'h8000, 16'd0);
      send_sample(1'b1, 16'd0, 16'd0, 16'd16384);
      for (int i = 0; i < 4; i++) send_sample(1'b0, 16'd0, 16'd12000, 16'd12000);
      for (int i = 0; i < 4; i++) send_sample(1'b0, 16'hd000, 16'd0, 16'd9000);
      for (int i = 0; i < 4; i++) send_sample(1'b0, 16'd0, 16'h8000, 16'd1000);

      // full alpha, zero threshold: equal magnitudes and zero roll
      drain_and_write(CSR_ALPHA, 15'd256);
      drain_and_write(CSR_THRESH, 15'd0);
      send_sample(1'b1, 16'd0, 16'd0, 16'd16384);
      send_sample(1'b0, 16'd0, 16'd0, 16'd16384);
      send_sample(1'b0, 16'd0, 16'd0, 16'd16384);
      send_sample(1'b0, 16'd0, 16'd0, 16'd16384);
      random_phase(300);

      quiet = 1;
      drain_and_write(CSR_ALPHA, 15'd0);
      drain_and_write(CSR_THRESH, 15'd23040);
      random_phase(150);
      quiet = 0;

      // alpha above full scale saturates
      drain_and_write(CSR_ALPHA, 15'h7fff);
      drain_and_write(CSR_THRESH, 15'h7fff);
      random_phase(100);

      drain_and_write(CSR_ALPHA, 15'd64);
      drain_and_write(CSR_THRESH, 15'd1920);
      random_phase(300);

      drain_and_write(CSR_ALPHA, 15'($urandom_range(1, 256)));
      drain_and_write(CSR_THRESH, 15'($urandom_range(200, 4000)));
      random_phase(250);

      drain_and_write(CSR_ALPHA, 15'd511);
      drain_and_write(CSR_THRESH, 15'd300);
      random_phase(150);

      @(negedge clock);
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/tdd_pkg.sv
rtl/core/tilt_direction_detector.sv
tb/tilt_direction_detector_check.sv
tb/tilt_direction_detector_test.sv
